### rtl/core/swrl_pkg.sv
// ----------------------------------------------------------------------------
// swrl_pkg - shared types and constants of the sliding window rate limiter
// Register indexes, field widths, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

    localparam int STAMP_W  = 64;
    localparam int MAXMSG_W = 5;
    localparam int WINDOW_W = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_MESSAGES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW_LENGTH = 2'd1;

    localparam logic [MAXMSG_W-1:0] MAXMSG_RESET = 5'd4;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd1000;

    typedef struct packed {
        logic [MAXMSG_W-1:0] max_messages;
        logic [WINDOW_W-1:0] window_length;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/core/sliding_window_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_core - sliding window log rate limiter
// Keeps the stamps of passed messages in a ring and flags each message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_timestamp) takes one message
//   stamp per transaction. Output channel (o_out_valid / i_out_ready /
//   o_accepted) returns one pass/fail flag per message, in order.
//   Config port: i_cfg_we with i_cfg_idx 0 = max_messages, 1 = window_length;
//   other indexes are ignored. Write only while the block is idle.
// Operation:
//   A message finding the ring empty passes; its result is registered in the
//   cycle after acceptance. Otherwise the age scan drops expired stamps from
//   the oldest on, reading one ring entry per cycle through the registered
//   stamp memory, then decides and, on a pass, pushes the stamp. The block
//   takes no new message during the scan. Each stamp is dropped once.
// Reset:
//   Ring empty (pointer and count cleared), max_messages = 4,
//   window_length = 1000. Ring contents are never read before written.
// Stall:
//   The result sits in an output register; a new message is taken in the
//   cycle the pending result is taken. One message is worked on at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rate_limiter_core
    import swrl_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [STAMP_W-1:0]    i_timestamp,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_accepted
);

    // ring pointer and held count widths
    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    t_cfg r_cfg, n_cfg;

    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [STAMP_W-1:0] rd_data;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [STAMP_W-1:0] wr_data;

    // config registers; out-of-range indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_MAX_MESSAGES: begin
                    n_cfg.max_messages = i_cfg_data[MAXMSG_W-1:0];
                end
                CFG_IDX_WINDOW_LENGTH: begin
                    n_cfg.window_length = i_cfg_data[WINDOW_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_messages  <= MAXMSG_RESET;
            r_cfg.window_length <= WINDOW_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // sequencer: age scan, limit decision, result register
    swrl_window_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_timestamp (i_timestamp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_accepted  (o_accepted),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // stamp ring
    swrl_stamp_mem #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (STAMP_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

### rtl/core/swrl_stamp_mem.sv
// ----------------------------------------------------------------------------
// swrl_stamp_mem - timestamp ring storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_stamp_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/core/swrl_window_ctrl.sv
// ----------------------------------------------------------------------------
// swrl_window_ctrl - ring sequencer of the rate limiter
// Pops expired stamps one per cycle, then decides and, on a pass, pushes the new stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_window_ctrl
    import swrl_pkg::*;
#(
    parameter int RING_DEPTH = 16,
    parameter int PTR_W      = 4,
    parameter int CNT_W      = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [STAMP_W-1:0] i_timestamp,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_accepted,
    output logic                    o_rd_en,
    output logic      [PTR_W-1:0]   o_rd_addr,
    input  wire logic [STAMP_W-1:0] i_rd_data,
    output logic                    o_wr_en,
    output logic      [PTR_W-1:0]   o_wr_addr,
    output logic      [STAMP_W-1:0] o_wr_data
);

    localparam int LIM_W = (CNT_W > MAXMSG_W) ? CNT_W : MAXMSG_W;
    localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(RING_DEPTH);
    localparam logic [LIM_W-1:0] DEPTH_L  = LIM_W'(RING_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_oldest, n_oldest;
    logic [CNT_W-1:0]   r_held, n_held;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic               r_out_valid, n_out_valid;
    logic               r_accepted, n_accepted;

    logic               in_fire;
    logic [PTR_W-1:0]   oldest_inc;
    logic [STAMP_W-1:0] age;
    logic               expired;
    logic [PTR_W-1:0]   eff_oldest;
    logic [CNT_W-1:0]   eff_held;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail_ptr;
    logic [LIM_W-1:0]   max_ext;
    logic [LIM_W-1:0]   limit;
    logic               pass;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;

    assign oldest_inc = (r_oldest == LAST_PTR) ? '0 : r_oldest + PTR_W'(1);
    assign age        = r_stamp - i_rd_data;
    assign expired    = age >= {{(STAMP_W-WINDOW_W){1'b0}}, i_cfg.window_length};

    // ring state as seen by the decision after this cycle's pop
    always_comb begin
        if (r_state == ST_CHECK && expired) begin
            eff_oldest = oldest_inc;
            eff_held   = r_held - CNT_W'(1);
        end else begin
            eff_oldest = r_oldest;
            eff_held   = r_held;
        end
    end

    always_comb begin
        tail_sum = SUM_W'(eff_oldest) + SUM_W'(eff_held);
        if (tail_sum >= DEPTH_S) begin
            tail_sum = tail_sum - DEPTH_S;
        end
    end
    assign tail_ptr = tail_sum[PTR_W-1:0];

    assign max_ext = LIM_W'(i_cfg.max_messages);
    assign limit   = (max_ext > DEPTH_L) ? DEPTH_L : max_ext;
    assign pass    = LIM_W'(eff_held) < limit;

    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_held      = r_held;
        n_stamp     = r_stamp;
        n_out_valid = r_out_valid && !i_out_ready;
        n_accepted  = r_accepted;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_oldest;
        o_wr_en     = 1'b0;
        o_wr_addr   = tail_ptr;
        o_wr_data   = r_stamp;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_stamp = i_timestamp;
                    if (r_held == '0) begin
                        // empty ring: always pass
                        o_wr_en     = 1'b1;
                        o_wr_data   = i_timestamp;
                        n_held      = CNT_W'(1);
                        n_out_valid = 1'b1;
                        n_accepted  = 1'b1;
                    end else begin
                        o_rd_en = 1'b1;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                n_oldest = eff_oldest;
                if (expired && eff_held != '0) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = oldest_inc;
                    n_held    = eff_held;
                end else begin
                    o_wr_en     = pass;
                    n_held      = pass ? eff_held + CNT_W'(1) : eff_held;
                    n_out_valid = 1'b1;
                    n_accepted  = pass;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp    <= n_stamp;
        r_accepted <= n_accepted;
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(RING_DEPTH))
        else $error("held count above ring depth");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("ring read and write in the same cycle");

    a_check_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> !r_out_valid)
        else $error("result pending while ring is scanned");

    a_nonempty_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_held != '0) |=> (r_state == ST_CHECK))
        else $error("non-empty ring skipped the age scan");
`endif

endmodule

`default_nettype wire
